>>> design/assert_macros.svh
// Assertion macros used by the multi-queue byte FIFO top level.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define MQ_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define MQ_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);

`endif

>>> design/mqbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and command struct for the multi-queue byte FIFO.
// No dependencies.
package mqbf_pkg;

  localparam int NUM_QUEUES = 8;
  localparam int DEPTH      = 512;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int QID_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 9;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 9;

  // Derived widths
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_W   = $clog2(NUM_QUEUES * DEPTH);
  localparam int CMP_W    = (PTR_W > OFF_W) ? PTR_W : OFF_W;
  localparam int SUM_W    = CMP_W + 1;
  localparam int QCMP_W   = 8;

  localparam logic [BYTE_W-1:0] BAD_BYTE = 8'd157;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ   = 2'd0,
    FN_DEQ   = 2'd1,
    FN_PEEK  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic execute;  // update pointers and access the byte store
    logic load;     // move the result into the output registers
  } cmd_t;

endpackage

>>> design/multi_queue_byte_fifo_top.sv
`timescale 1ns / 1ps
// Multi-queue byte FIFO. out_valid rises once an accepted transaction has gone through its
// capture, byte-store access (read data registered) and result load steps; the load waits
// while an untaken result is held. No new transaction is accepted before its result is loaded.
// Reset (synchronous, rst_n low) clears all head and tail pointers and the handshake state;
// the byte store is not cleared and no clearing pass runs, so the block is ready at once.
`include "assert_macros.svh"

module multi_queue_byte_fifo_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mqbf_pkg::FUNC_W-1:0]   in_func,
  input  logic [mqbf_pkg::QID_W-1:0]    in_queue_id,
  input  logic [mqbf_pkg::BYTE_W-1:0]   in_value,
  input  logic [mqbf_pkg::OFF_W-1:0]    in_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mqbf_pkg::BYTE_W-1:0]   out_data,
  output logic [mqbf_pkg::STAT_W-1:0]   out_status,
  output logic [mqbf_pkg::LEN_W-1:0]    out_length,
  output logic                          out_is_empty
);
  import mqbf_pkg::*;

  cmd_t cmd;

  // Sequencer
  mqbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, store and result registers
  mqbf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .in_offset    (in_offset),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_length   (out_length),
    .out_is_empty (out_is_empty)
  );

  // An accepted transaction blocks the input until its result is loaded
  `MQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready after accept")
  // Empty dequeue returns the invalid byte on an empty queue
  `MQ_ASSERT_IMPL(a_empty_deq, out_valid && (out_status == ST_EMPTY), (out_data == BAD_BYTE) && out_is_empty, "bad empty dequeue result")
  // Dropped enqueue leaves a non-empty queue and returns zero
  `MQ_ASSERT_IMPL(a_full_enq, out_valid && (out_status == ST_FULL), (out_data == '0) && !out_is_empty, "bad full enqueue result")

endmodule

>>> design/mqbf_ctrl.sv
`timescale 1ns / 1ps
// Controller for the multi-queue byte FIFO: sequences capture, execute, load.
// Depends on mqbf_pkg.
module mqbf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mqbf_pkg::cmd_t cmd
);
  import mqbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/mqbf_dp.sv
`timescale 1ns / 1ps
// Datapath for the multi-queue byte FIFO: pointers, byte store, result registers.
// Depends on mqbf_pkg; driven by mqbf_ctrl commands.
module mqbf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mqbf_pkg::cmd_t                cmd,
  input  logic [mqbf_pkg::FUNC_W-1:0]   in_func,
  input  logic [mqbf_pkg::QID_W-1:0]    in_queue_id,
  input  logic [mqbf_pkg::BYTE_W-1:0]   in_value,
  input  logic [mqbf_pkg::OFF_W-1:0]    in_offset,
  output logic [mqbf_pkg::BYTE_W-1:0]   out_data,
  output logic [mqbf_pkg::STAT_W-1:0]   out_status,
  output logic [mqbf_pkg::LEN_W-1:0]    out_length,
  output logic                          out_is_empty
);
  import mqbf_pkg::*;

  // Captured transaction
  logic [FUNC_W-1:0] func_r;
  logic [QID_W-1:0]  qid_r;
  logic [BYTE_W-1:0] value_r;
  logic [OFF_W-1:0]  offset_r;

  // Queue pointers and byte store
  logic [PTR_W-1:0]  head_r [NUM_QUEUES];
  logic [PTR_W-1:0]  tail_r [NUM_QUEUES];
  logic [BYTE_W-1:0] mem [NUM_QUEUES * DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Result held between execute and load
  status_t           res_status_r;
  logic [PTR_W-1:0]  res_len_r;
  logic              res_in_range_r;
  logic              res_use_mem_r;
  logic [BYTE_W-1:0] res_const_r;

  // Output registers
  logic [BYTE_W-1:0] out_data_r;
  logic [STAT_W-1:0] out_status_r;
  logic [LEN_W-1:0]  out_length_r;
  logic              out_is_empty_r;

  // Execute-stage logic
  func_t             func;
  logic [QIDX_W-1:0] qidx;
  logic              in_range;
  logic [PTR_W-1:0]  head, tail, tail_inc, head_inc, len;
  logic              full, empty, peek_ok;
  logic [SUM_W-1:0]  peek_sum, peek_wrap;
  logic [PTR_W-1:0]  peek_slot, rd_slot;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] addr;
  status_t           status;
  logic [PTR_W-1:0]  len_after;
  logic              use_mem;
  logic [BYTE_W-1:0] const_data;
  logic [CMP_W-1:0]  len_ext;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      qid_r    <= in_queue_id;
      value_r  <= in_value;
      offset_r <= in_offset;
    end
  end

  // Decode the operation against the addressed queue
  always_comb begin
    func     = func_t'(func_r);
    qidx     = QIDX_W'(qid_r);
    in_range = (QCMP_W'(qid_r) < QCMP_W'(NUM_QUEUES));
    head     = head_r[qidx];
    tail     = tail_r[qidx];
    tail_inc = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
    head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
    full     = (tail_inc == head);
    empty    = (head == tail);
    len      = (tail >= head) ? (tail - head) : (tail + PTR_W'(DEPTH) - head);
    peek_ok  = (CMP_W'(offset_r) < CMP_W'(len));

    // wrap the peek position once; only used when inside the length
    peek_sum  = SUM_W'(head) + SUM_W'(offset_r);
    peek_wrap = (peek_sum >= SUM_W'(DEPTH)) ? (peek_sum - SUM_W'(DEPTH)) : peek_sum;
    peek_slot = peek_wrap[PTR_W-1:0];

    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_slot    = head;
    status     = ST_OK;
    len_after  = len;
    use_mem    = 1'b0;
    const_data = '0;
    unique case (func)
      FN_ENQ: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr_en     = in_range;
          len_after = len + PTR_W'(1);
        end
      end
      FN_DEQ: begin
        if (empty) begin
          status     = ST_EMPTY;
          const_data = BAD_BYTE;
        end else begin
          rd_en     = in_range;
          use_mem   = 1'b1;
          len_after = len - PTR_W'(1);
        end
      end
      FN_PEEK: begin
        if (!peek_ok) begin
          status     = ST_RANGE;
          const_data = BAD_BYTE;
        end else begin
          rd_en   = in_range;
          rd_slot = peek_slot;
          use_mem = 1'b1;
        end
      end
      FN_CLEAR: begin
        len_after = '0;
      end
      default: begin
        len_after = len;
      end
    endcase

    addr = ADDR_W'(qidx) * ADDR_W'(DEPTH) + ADDR_W'(wr_en ? tail : rd_slot);
  end

  // Pointer update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (cmd.execute && in_range) begin
      if (func == FN_CLEAR) begin
        head_r[qidx] <= '0;
        tail_r[qidx] <= '0;
      end else if (wr_en) begin
        tail_r[qidx] <= tail_inc;
      end else if (func == FN_DEQ && rd_en) begin
        head_r[qidx] <= head_inc;
      end
    end
  end

  // Byte store: at most one access per transaction, read data registered
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (wr_en) begin
        mem[addr] <= value_r;
      end else if (rd_en) begin
        rd_data_r <= mem[addr];
      end
    end
  end

  // Hold the result fields until load
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status_r   <= status;
      res_len_r      <= len_after;
      res_in_range_r <= in_range;
      res_use_mem_r  <= use_mem;
      res_const_r    <= const_data;
    end
  end

  assign len_ext = CMP_W'(res_len_r);

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (res_in_range_r) begin
        out_data_r     <= res_use_mem_r ? rd_data_r : res_const_r;
        out_status_r   <= res_status_r;
        out_length_r   <= len_ext[LEN_W-1:0];
        out_is_empty_r <= (res_len_r == '0);
      end else begin
        out_data_r     <= '0;
        out_status_r   <= ST_OK;
        out_length_r   <= '0;
        out_is_empty_r <= 1'b1;
      end
    end
  end

  assign out_data     = out_data_r;
  assign out_status   = out_status_r;
  assign out_length   = out_length_r;
  assign out_is_empty = out_is_empty_r;

endmodule

>>> test/mqbf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-queue byte FIFO: watches both channels, predicts each result
// with its own queue model and compares every field. Depends on mqbf_pkg.
module mqbf_checker
  import mqbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [QID_W-1:0]  in_queue_id,
  input  logic [BYTE_W-1:0] in_value,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_data,
  input  logic [STAT_W-1:0] out_status,
  input  logic [LEN_W-1:0]  out_length,
  input  logic              out_is_empty,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } op_result_t;

  // Shadow copy of the queues
  logic [BYTE_W-1:0] ring_mem [NUM_QUEUES][DEPTH];
  int                head_idx [NUM_QUEUES];
  int                tail_idx [NUM_QUEUES];

  op_result_t awaited_q [$];
  op_result_t oldest;
  int         result_no;

  function automatic int fill_level(int q);
    return (tail_idx[q] + DEPTH - head_idx[q]) % DEPTH;
  endfunction

  // Apply one operation to the shadow queues and return what the block should answer
  function automatic op_result_t apply_op(func_t fn, int q, logic [BYTE_W-1:0] val, int off);
    op_result_t r;
    int         lvl;
    r.data   = '0;
    r.status = ST_OK;
    case (fn)
      FN_ENQ: begin
        if ((tail_idx[q] + 1) % DEPTH == head_idx[q]) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[q][tail_idx[q]] = val;
          tail_idx[q] = (tail_idx[q] + 1) % DEPTH;
        end
      end
      FN_DEQ: begin
        if (head_idx[q] == tail_idx[q]) begin
          r.data   = BAD_BYTE;
          r.status = ST_EMPTY;
        end else begin
          r.data = ring_mem[q][head_idx[q]];
          head_idx[q] = (head_idx[q] + 1) % DEPTH;
        end
      end
      FN_PEEK: begin
        if (off >= fill_level(q)) begin
          r.data   = BAD_BYTE;
          r.status = ST_RANGE;
        end else begin
          r.data = ring_mem[q][(head_idx[q] + off) % DEPTH];
        end
      end
      default: begin
        head_idx[q] = 0;
        tail_idx[q] = 0;
      end
    endcase
    lvl        = fill_level(q);
    r.length   = lvl[LEN_W-1:0];
    r.is_empty = (lvl == 0);
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_idx[q] = 0;
        tail_idx[q] = 0;
      end
      awaited_q.delete();
      result_no = 0;
    end else begin
      // Check the result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding", result_no));
        end else begin
          oldest = awaited_q.pop_front();
          if (out_data !== oldest.data)
            report_mismatch($sformatf("result %0d data got %0d want %0d",
                                      result_no, out_data, oldest.data));
          if (out_status !== oldest.status)
            report_mismatch($sformatf("result %0d status got %0d want %0d",
                                      result_no, out_status, oldest.status));
          if (out_length !== oldest.length)
            report_mismatch($sformatf("result %0d length got %0d want %0d",
                                      result_no, out_length, oldest.length));
          if (out_is_empty !== oldest.is_empty)
            report_mismatch($sformatf("result %0d is_empty got %0d want %0d",
                                      result_no, out_is_empty, oldest.is_empty));
        end
        result_no++;
      end
      // Predict the accepted input transaction
      if (in_valid && in_ready)
        awaited_q.push_back(apply_op(func_t'(in_func), int'(in_queue_id), in_value,
                                     int'(in_offset)));
    end
    pending = awaited_q.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top of the multi-queue byte FIFO testbench: clock, reset, stimulus and verdict.
// Depends on mqbf_pkg, multi_queue_byte_fifo_top and mqbf_checker.
module tb;
  import mqbf_pkg::*;

  localparam int RAND_OPS  = 760;
  localparam int LONG_HOLD = 90;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [QID_W-1:0]  in_queue_id;
  logic [BYTE_W-1:0] in_value;
  logic [OFF_W-1:0]  in_offset;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_data;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0]  out_length;
  logic              out_is_empty;

  int  fail_count;
  int  pending;
  int  sent_count;
  int  op_tally [4];
  bit  quiet;
  bit  held_long;

  multi_queue_byte_fifo_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .in_offset    (in_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_length   (out_length),
    .out_is_empty (out_is_empty)
  );

  mqbf_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .in_offset    (in_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_length   (out_length),
    .out_is_empty (out_is_empty),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one transaction from a falling edge, hold it until accepted, maybe idle after
  task automatic issue_op(func_t fn, int q, int val, int off);
    in_func     <= fn;
    in_queue_id <= q[QID_W-1:0];
    in_value    <= val[BYTE_W-1:0];
    in_offset   <= off[OFF_W-1:0];
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    op_tally[fn]++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int    fq;
    int    q;
    int    sel;
    int    off;
    func_t fn;
    in_valid    <= 1'b0;
    in_func     <= FN_ENQ;
    in_queue_id <= '0;
    in_value    <= '0;
    in_offset   <= '0;
    rst_n       <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty queues, byte extremes, offsets at and past the length, clears
    issue_op(FN_DEQ,   0, 8'h00, 0);
    issue_op(FN_PEEK,  0, 8'h00, 0);
    issue_op(FN_PEEK,  7, 8'hff, 511);
    issue_op(FN_ENQ,   0, 8'h00, 0);
    issue_op(FN_ENQ,   0, 8'hff, 511);
    issue_op(FN_ENQ,   7, 8'ha5, 0);
    issue_op(FN_PEEK,  0, 8'h00, 0);
    issue_op(FN_PEEK,  0, 8'h00, 1);
    issue_op(FN_PEEK,  0, 8'h00, 2);
    issue_op(FN_PEEK,  0, 8'h00, 511);
    issue_op(FN_DEQ,   0, 8'hff, 0);
    issue_op(FN_DEQ,   0, 8'h00, 0);
    issue_op(FN_DEQ,   0, 8'h00, 0);
    issue_op(FN_ENQ,   3, 8'h5a, 0);
    issue_op(FN_ENQ,   3, 8'h81, 0);
    issue_op(FN_CLEAR, 3, 8'hff, 511);
    issue_op(FN_DEQ,   3, 8'h00, 0);
    issue_op(FN_PEEK,  3, 8'h00, 0);
    issue_op(FN_CLEAR, 5, 8'h00, 0);
    issue_op(FN_ENQ,   7, 8'h3c, 0);
    issue_op(FN_DEQ,   7, 8'h00, 0);
    issue_op(FN_CLEAR, 7, 8'h00, 0);
    wait_drained();

    // Fill one queue past capacity so the last enqueues are rejected
    fq = $urandom_range(0, NUM_QUEUES - 1);
    for (int i = 0; i < DEPTH + 2; i++)
      issue_op(FN_ENQ, fq, $urandom_range(0, 255), $urandom_range(0, 511));
    issue_op(FN_PEEK, fq, $urandom_range(0, 255), DEPTH - 2);
    issue_op(FN_PEEK, fq, $urandom_range(0, 255), DEPTH - 1);
    // Advance the head, then refill so the tail wraps round the ring
    for (int i = 0; i < 40; i++)
      issue_op(FN_DEQ, fq, $urandom_range(0, 255), $urandom_range(0, 511));
    for (int i = 0; i < 45; i++)
      issue_op(FN_ENQ, fq, $urandom_range(0, 255), $urandom_range(0, 511));
    for (int i = 0; i < 20; i++)
      issue_op(FN_PEEK, fq, $urandom_range(0, 255), $urandom_range(400, 511));
    issue_op(FN_CLEAR, fq, $urandom_range(0, 255), $urandom_range(0, 511));

    // Random mix over all queues, enqueue-biased so the queues hold some bytes
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i == RAND_OPS / 2) wait_drained();
      if (i == RAND_OPS - 120) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      q   = $urandom_range(0, NUM_QUEUES - 1);
      if (sel < 42)      fn = FN_ENQ;
      else if (sel < 70) fn = FN_DEQ;
      else if (sel < 96) fn = FN_PEEK;
      else               fn = FN_CLEAR;
      // Offsets mostly fall in 0 to 12, the rest anywhere in 0 to 511
      off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 12);
      issue_op(fn, q, $urandom_range(0, 255), off);
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    $display("Summary: %0d transactions (%0d enqueue, %0d dequeue, %0d peek, %0d clear)",
             sent_count, op_tally[FN_ENQ], op_tally[FN_DEQ], op_tally[FN_PEEK],
             op_tally[FN_CLEAR]);
    $display("Summary: one queue filled past capacity with pointer wrap, %0d-cycle output stall",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off while the sender keeps offering
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && sent_count >= 300) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
